[src/kct_pkg.sv]
// Shared types, codes and default sizes for the keyed counter table.
package kct_pkg;

    // Default sizes of the table.
    localparam int unsigned ENTRIES_DEF    = 16;
    localparam int unsigned TAG_BITS_DEF   = 16;
    localparam int unsigned COUNT_BITS_DEF = 31;

    // Fixed widths of the request and result fields.
    localparam int unsigned TAG_IN_W    = 16;
    localparam int unsigned AMOUNT_W    = 32;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned COUNT_OUT_W = 31;

    // Packed stream widths, rounded up to whole bytes.
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 40;

    typedef enum logic {
        KIND_ADD    = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW      = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_INVALID  = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_FULL     = 3'd6
    } status_t;

    typedef enum logic {
        CTRL_IDLE   = 1'b0,
        CTRL_UPDATE = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the request and look the tag up
        logic commit;   // write the entry back and load the result
    } kct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_blocked;  // result register holds a transfer that is not taken
    } kct_stat_t;

endpackage

[src/kct_ctrl.sv]
// Controller state machine of the keyed counter table.
module kct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  kct_pkg::kct_stat_t stat,
    output kct_pkg::kct_cmd_t  cmd
);
    import kct_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTRL_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = CTRL_UPDATE;
                end
            end
            CTRL_UPDATE:
            begin
                if (!stat.out_blocked)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            CTRL_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            CTRL_UPDATE:
            begin
                cmd.commit = !stat.out_blocked;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[src/kct_datapath.sv]
// Datapath of the keyed counter table: tag store, count memory and result register.
module kct_datapath #(
    parameter int unsigned ENTRIES    = kct_pkg::ENTRIES_DEF,
    parameter int unsigned TAG_BITS   = kct_pkg::TAG_BITS_DEF,
    parameter int unsigned COUNT_BITS = kct_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kct_pkg::kct_cmd_t                   cmd,
    output kct_pkg::kct_stat_t                  stat,
    input  logic                                req_kind,
    input  logic [kct_pkg::TAG_IN_W-1:0]        req_tag,
    input  logic signed [kct_pkg::AMOUNT_W-1:0] req_amount,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [kct_pkg::STATUS_W-1:0]        res_status,
    output logic [kct_pkg::COUNT_OUT_W-1:0]     res_count
);
    import kct_pkg::*;

    localparam int unsigned IW       = $clog2(ENTRIES);
    localparam int unsigned KEY_BITS = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
    localparam int unsigned SW       = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;

    // Tag store and valid bits: compared in parallel.
    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [TAG_BITS-1:0] tag_reg [ENTRIES];

    // Count memory: one write and one registered read port.
    logic [COUNT_BITS-1:0] count_mem [ENTRIES];

    // Lookup stage.
    logic [TAG_BITS-1:0] key;
    logic [ENTRIES-1:0]  match;
    logic                hit;
    logic [IW-1:0]       hit_idx;
    logic                free_ok;
    logic [IW-1:0]       free_idx;

    // Registered request and lookup result.
    logic                  kind_reg;
    logic [TAG_BITS-1:0]   key_reg;
    logic                  key_zero_reg;
    logic [AMOUNT_W-1:0]   amount_reg;
    logic                  hit_reg;
    logic [IW-1:0]         hit_idx_reg;
    logic                  free_ok_reg;
    logic [IW-1:0]         free_idx_reg;
    logic [COUNT_BITS-1:0] count_rd_reg;

    // Update stage.
    logic          amt_pos;
    logic [SW-1:0] amt_ext;
    logic [SW-1:0] cnt_ext;
    logic [SW-1:0] cnt_max;
    logic [SW-1:0] sum;
    logic [SW-1:0] add_cnt;
    logic [SW-1:0] new_cnt;
    logic [SW-1:0] sub_cnt;
    status_t       upd_status;
    logic [SW-1:0] upd_count;
    logic          cnt_we;
    logic [IW-1:0] cnt_waddr;
    logic          tag_we;
    logic          valid_set;
    logic          valid_clr;

    // Result register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    assign key = TAG_BITS'(req_tag[KEY_BITS-1:0]);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == key);
        end
    end

    // The lowest matching entry and the lowest free entry win.
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg     <= req_kind;
            key_reg      <= key;
            key_zero_reg <= (key == '0);
            amount_reg   <= req_amount;
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            free_ok_reg  <= free_ok;
            free_idx_reg <= free_idx;
        end
    end

    assign amt_pos = (amount_reg != '0) && !amount_reg[AMOUNT_W-1];
    assign amt_ext = SW'(amount_reg[AMOUNT_W-2:0]);
    assign cnt_ext = SW'(count_rd_reg);
    assign cnt_max = SW'({COUNT_BITS{1'b1}});
    assign sum     = cnt_ext + amt_ext;
    assign add_cnt = (sum > cnt_max) ? cnt_max : sum;
    assign new_cnt = (amt_ext > cnt_max) ? cnt_max : amt_ext;
    assign sub_cnt = cnt_ext - amt_ext;

    always_comb
    begin
        upd_status = ST_INVALID;
        upd_count  = '0;
        cnt_we     = 1'b0;
        cnt_waddr  = hit_idx_reg;
        tag_we     = 1'b0;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        if (key_zero_reg)
        begin
            upd_status = ST_INVALID;
        end
        else if (!amt_pos)
        begin
            upd_status = ST_IGNORED;
            upd_count  = hit_reg ? cnt_ext : '0;
        end
        else if (kind_reg == KIND_ADD)
        begin
            if (hit_reg)
            begin
                upd_status = ST_UPDATED;
                upd_count  = add_cnt;
                cnt_we     = 1'b1;
            end
            else if (free_ok_reg)
            begin
                upd_status = ST_NEW;
                upd_count  = new_cnt;
                cnt_we     = 1'b1;
                cnt_waddr  = free_idx_reg;
                tag_we     = 1'b1;
                valid_set  = 1'b1;
            end
            else
            begin
                upd_status = ST_FULL;
            end
        end
        else
        begin
            if (!hit_reg)
            begin
                upd_status = ST_NOTFOUND;
            end
            else if (cnt_ext <= amt_ext)
            begin
                upd_status = ST_REMOVED;
                valid_clr  = 1'b1;
            end
            else
            begin
                upd_status = ST_UPDATED;
                upd_count  = sub_cnt;
                cnt_we     = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit && valid_set)
        begin
            valid_next[free_idx_reg] = 1'b1;
        end
        if (cmd.commit && valid_clr)
        begin
            valid_next[hit_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && tag_we)
        begin
            tag_reg[free_idx_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && cnt_we)
        begin
            count_mem[cnt_waddr] <= upd_count[COUNT_BITS-1:0];
        end
        if (cmd.capture)
        begin
            count_rd_reg <= count_mem[hit_idx];
        end
    end

    assign out_valid_next = cmd.commit ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= upd_status;
            out_count_reg  <= upd_count[COUNT_OUT_W-1:0];
        end
    end

    assign stat.out_blocked = out_valid_reg && !res_ready;
    assign res_valid        = out_valid_reg;
    assign res_status       = out_status_reg;
    assign res_count        = out_count_reg;

endmodule

[src/keyed_counter_table.sv]
// Top level of the keyed counter table: stream ports, controller and datapath.
//
// Usage: each request arrives as one transfer on the slave stream (s_*) and
// gives exactly one result transfer on the master stream (m_*). A request
// names a tag, a signed amount and whether to add or remove; the result
// carries a status code and the count of the tag after the request.
//
// Operation: when a request is taken, every valid entry's tag is compared
// at once and the matching entry's count is read from the count memory into
// a register. The update state then does the read-modify-write of that one
// entry and loads the result register. A new request is taken only once the
// update of the request before it is done.
//
// Reset clears every valid bit, so the table starts empty; the tags and
// counts themselves are not cleared and are only read behind a valid bit.
// When the receiver stalls, one finished result waits in the result register
// while the next request is still taken and looked up; it then holds its
// update until the result register is free.
module keyed_counter_table #(
    parameter int unsigned ENTRIES    = kct_pkg::ENTRIES_DEF,
    parameter int unsigned TAG_BITS   = kct_pkg::TAG_BITS_DEF,
    parameter int unsigned COUNT_BITS = kct_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Request stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [kct_pkg::S_DATA_W-1:0] s_tdata,   // tag[15:0], amount[47:16]
    input  logic                        s_tuser,   // kind (0 add, 1 remove)
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [kct_pkg::M_DATA_W-1:0] m_tdata    // status[2:0], count_after[33:3], zeros
);
    import kct_pkg::*;

    kct_cmd_t  cmd;
    kct_stat_t stat;

    logic [STATUS_W-1:0]    res_status;
    logic [COUNT_OUT_W-1:0] res_count;

    // The controller sequences lookup and write-back of each transfer.
    kct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the table and the result register.
    kct_datapath #(
        .ENTRIES    (ENTRIES),
        .TAG_BITS   (TAG_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_kind   (s_tuser),
        .req_tag    (s_tdata[TAG_IN_W-1:0]),
        .req_amount (s_tdata[TAG_IN_W+AMOUNT_W-1:TAG_IN_W]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_count  (res_count)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_tdata = {{(M_DATA_W - STATUS_W - COUNT_OUT_W){1'b0}}, res_count, res_status};

endmodule

[test/tb.sv]
// Self-checking stream testbench for the keyed counter table.
`timescale 1ns / 1ps

module tb;
    import kct_pkg::*;

    localparam int unsigned SLOTS = ENTRIES_DEF;
    localparam logic [COUNT_OUT_W-1:0] COUNT_CEIL = {COUNT_OUT_W{1'b1}};
    localparam int unsigned RANDOM_REQUESTS = 850;

    typedef struct {
        kind_t                      kind;
        logic [TAG_IN_W-1:0]        tag;
        logic [AMOUNT_W-1:0]        amount;
    } request_t;

    typedef struct {
        status_t                    status;
        logic [COUNT_OUT_W-1:0]     count;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;   // tag[15:0], amount[47:16]
    logic                  s_tuser = 1'b0; // kind (0 add, 1 remove)
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;        // status[2:0], count_after[33:3], zeros

    // Shadow copy of the counter table.
    logic                   slot_used [SLOTS];
    logic [TAG_IN_W-1:0]    slot_tag [SLOTS];
    logic [COUNT_OUT_W-1:0] slot_count [SLOTS];

    request_t request_q[$];
    outcome_t outcome_q[$];
    int       errors = 0;
    logic     req_taken = 1'b0;
    int       gap_left = 0;
    int       burst_left = 1;
    int       pattern_left = 0;
    logic [31:0] stall_pattern = '1;

    keyed_counter_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // Applies one request to the shadow table and returns the outcome it should give.
    function automatic outcome_t apply_request(kind_t kind, logic [TAG_IN_W-1:0] tag,
                                               logic [AMOUNT_W-1:0] amount);
        outcome_t res;
        int hit;
        int free_slot;
        logic [COUNT_OUT_W-1:0] c;
        res.status = ST_INVALID;
        res.count  = '0;
        hit = -1;
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_tag[i] == tag)
                hit = i;
            if (!slot_used[i])
                free_slot = i;
        end
        if (tag == '0) begin
            res.status = ST_INVALID;
        end
        else if (amount == '0 || amount[AMOUNT_W-1]) begin
            // Non-positive amounts leave the table alone but still report the count.
            res.status = ST_IGNORED;
            if (hit >= 0)
                res.count = slot_count[hit];
        end
        else if (kind == KIND_ADD) begin
            if (hit >= 0) begin
                c = slot_count[hit];
                if (amount >= {1'b0, COUNT_CEIL - c})
                    c = COUNT_CEIL;
                else
                    c = c + amount[COUNT_OUT_W-1:0];
                slot_count[hit] = c;
                res.count  = c;
                res.status = ST_UPDATED;
            end
            else if (free_slot < 0) begin
                res.status = ST_FULL;
            end
            else begin
                slot_used[free_slot]  = 1'b1;
                slot_tag[free_slot]   = tag;
                slot_count[free_slot] = amount[COUNT_OUT_W-1:0];
                res.count  = amount[COUNT_OUT_W-1:0];
                res.status = ST_NEW;
            end
        end
        else begin
            if (hit < 0) begin
                res.status = ST_NOTFOUND;
            end
            else if ({1'b0, slot_count[hit]} <= amount) begin
                slot_used[hit] = 1'b0;
                res.status = ST_REMOVED;
            end
            else begin
                slot_count[hit] = slot_count[hit] - amount[COUNT_OUT_W-1:0];
                res.count  = slot_count[hit];
                res.status = ST_UPDATED;
            end
        end
        return res;
    endfunction

    task automatic queue_request(kind_t kind, logic [TAG_IN_W-1:0] tag,
                                 logic [AMOUNT_W-1:0] amount);
        request_t r;
        r.kind   = kind;
        r.tag    = tag;
        r.amount = amount;
        request_q.push_back(r);
    endtask

    // Request sender: transfers go out in bursts separated by random gaps.
    always @(negedge clk)
    begin : drive_requests
        request_t r;
        logic     next_valid;
        if (rst_n && (!s_tvalid || req_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end
            else if (request_q.size() > 0) begin
                r = request_q.pop_front();
                s_tdata    <= {r.amount, r.tag};
                s_tuser    <= r.kind;
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    // Now and then a long burst with no gap at all.
                    if ($urandom_range(0, 4) == 0) begin
                        burst_left = $urandom_range(30, 80);
                        gap_left   = 0;
                    end
                    else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Result receiver: back-pressure follows a rotating 32-bit pattern, renewed once it has fully rotated.
    always @(negedge clk)
    begin : drive_stalls
        if (rst_n) begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = '1;
                    1: stall_pattern = $urandom();
                    2: stall_pattern = $urandom() & $urandom();
                    default: stall_pattern = $urandom() | $urandom();
                endcase
                pattern_left = 32;
            end
            m_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
            pattern_left--;
        end
    end

    // Observes both streams at the rising edge: predicts on each accepted request and
    // checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin : observe
        outcome_t want;
        if (rst_n) begin
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                outcome_q.push_back(apply_request(kind_t'(s_tuser), s_tdata[15:0],
                                                  s_tdata[47:16]));
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result transfer: status %0d, count_after %0d",
                           m_tdata[2:0], m_tdata[33:3]);
                    errors++;
                end
                else begin
                    want = outcome_q.pop_front();
                    if (m_tdata[2:0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[33:3] !== want.count) begin
                        $error("count_after: expected %0d, got %0d", want.count,
                               m_tdata[33:3]);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [TAG_IN_W-1:0] tag_pool [24];
        int                  add_share;
        kind_t               kind;
        logic [TAG_IN_W-1:0] tag;
        logic [AMOUNT_W-1:0] amount;
        int                  pick;

        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_tag[i]   = '0;
            slot_count[i] = '0;
        end

        // Directed part: invalid tag before amount, ignored amounts, saturation,
        // partial and exact removal, not found, and a table filled up to full.
        queue_request(KIND_ADD,    16'h0000, 32'd5);
        queue_request(KIND_REMOVE, 16'h0000, 32'hFFFF_FFFF);
        queue_request(KIND_ADD,    16'h0001, 32'd0);
        queue_request(KIND_REMOVE, 16'h0001, 32'h8000_0000);
        queue_request(KIND_ADD,    16'h0001, 32'h7FFF_FFFF);
        queue_request(KIND_ADD,    16'h0001, 32'd1);
        queue_request(KIND_ADD,    16'h0001, 32'hFFFF_FFFB);
        queue_request(KIND_REMOVE, 16'h0001, 32'h7FFF_FFFE);
        queue_request(KIND_REMOVE, 16'h0001, 32'd1);
        queue_request(KIND_REMOVE, 16'h0002, 32'd3);
        queue_request(KIND_ADD,    16'hFFFF, 32'd10);
        for (int i = 0; i < SLOTS - 1; i++)
            queue_request(KIND_ADD, 16'h0100 + i[15:0], 32'd7 + i);
        queue_request(KIND_ADD,    16'h5A5A, 32'd1);
        queue_request(KIND_REMOVE, 16'hFFFF, 32'd100);

        // Random part: mostly valid requests on a small set of tags so that hits,
        // removals and a full table all recur; the mix of adds drifts over time.
        for (int i = 0; i < 24; i++)
            tag_pool[i] = TAG_IN_W'($urandom_range(1, 16'hFFFF));
        add_share = 60;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 150 == 0)
                add_share = $urandom_range(25, 85);
            kind = ($urandom_range(0, 99) < add_share) ? KIND_ADD : KIND_REMOVE;
            pick = $urandom_range(0, 99);
            if (pick < 85)
                tag = tag_pool[$urandom_range(0, 23)];
            else if (pick < 90)
                tag = '0;
            else
                tag = TAG_IN_W'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 60)
                amount = $urandom_range(1, 50);
            else if (pick < 75)
                amount = $urandom_range(1, 32'h7FFF_FFFF);
            else if (pick < 85)
                amount = 32'h7FFF_FFFF - $urandom_range(0, 100);
            else if (pick < 90)
                amount = '0;
            else if (pick < 95)
                amount = 32'h8000_0000 | $urandom();
            else
                amount = $urandom();
            queue_request(kind, tag, amount);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every request sent, every result seen, then a short settling time.
        do @(posedge clk); while (request_q.size() != 0 || s_tvalid);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("[keyed_counter_table] OK");
        else
            $display("[keyed_counter_table] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("[keyed_counter_table] ERROR");
        $finish;
    end

endmodule

[sim.f]
src/kct_pkg.sv
src/kct_ctrl.sv
src/kct_datapath.sv
src/keyed_counter_table.sv
test/tb.sv
